// ===== rtl/core/lrt_pkg.sv =====
// ----------------------------------------------------------------------------
// lrt_pkg : shared types and constants of the LRU replacement tracker
// Sizes, action and status codes, and the controller command word.
// ----------------------------------------------------------------------------
`default_nettype none

package lrt_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 16;

    localparam int RANK_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed field widths of the ports
    localparam int ACT_W    = 2;
    localparam int IKEY_W   = 16;
    localparam int STAT_W   = 2;
    localparam int VKEY_W   = 16;
    localparam int OCNT_W   = 5;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_EVICT  = 2'd1,
        ACT_ERASE  = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture the input word
        logic commit;   // apply the action and load the result register
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/lru_replacement_tracker_core.sv =====
// ----------------------------------------------------------------------------
// lru_replacement_tracker_core : LRU replacement tracker, top level
// The input word is captured when accepted in S_IDLE; in S_EXEC the action
//   is applied and the result loaded once the previous result is taken.
// No new word is taken while one is in S_EXEC: a word is captured, then
//   compared against and applied to the slot array.
// Reset: synchronous, active low; clears valid bits, ranks, count and the
//   result valid flag. Slot keys are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_replacement_tracker_core
    import lrt_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    // input channel
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [ACT_W-1:0]   i_action,
    input  wire  [IKEY_W-1:0]  i_key,
    // result channel
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [VKEY_W-1:0]  o_victim_key,
    output logic [OCNT_W-1:0]  o_count
);

    // Command word from the sequencer: load captures the input word into
    // the datapath; commit applies the action to the slot array and loads
    // the result register in the same edge. Commit waits while a previous
    // result is still stalled, so no result is ever overwritten.
    t_cmd cmd;

    lrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Slot array: each slot holds a key, a valid bit and a recency rank
    // (0 most recent). All slots compare against the key at once.
    lrt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_key        (i_key),
        .o_status     (o_status),
        .o_victim_key (o_victim_key),
        .o_count      (o_count)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrt_ctrl : sequencer of the LRU replacement tracker
// Two-state machine: capture a word, then apply it once the result slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module lrt_ctrl
    import lrt_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  wire  i_out_stall,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && i_out_stall;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the previous result has been taken
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/core/lrt_dp.sv =====
// ----------------------------------------------------------------------------
// lrt_dp : datapath of the LRU replacement tracker
// Slot keys, valid bits and recency ranks with a parallel key compare.
// ----------------------------------------------------------------------------
`default_nettype none

module lrt_dp
    import lrt_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    input  wire  [ACT_W-1:0]   i_action,
    input  wire  [IKEY_W-1:0]  i_key,
    output logic [STAT_W-1:0]  o_status,
    output logic [VKEY_W-1:0]  o_victim_key,
    output logic [OCNT_W-1:0]  o_count
);

    logic [ACT_W-1:0]    r_act;
    logic [KEY_BITS-1:0] r_key;

    logic [KEY_BITS-1:0] r_slot_key [CAPACITY];
    logic [CAPACITY-1:0] r_valid, n_valid;
    logic [RANK_W-1:0]   r_rank [CAPACITY];
    logic [RANK_W-1:0]   n_rank [CAPACITY];
    logic [CNT_W-1:0]    r_count, n_count;

    logic [STAT_W-1:0]   r_status, n_status;
    logic [KEY_BITS-1:0] r_victim, n_victim;

    logic [KEY_BITS+IKEY_W-1:0] key_ext;
    logic [CAPACITY-1:0] hit, lru, free_oh, rm, key_we;
    logic                hit_any, lru_any, full, ins_new, do_rm;
    logic [RANK_W-1:0]   hit_rank, lru_rank, rm_rank;
    logic [KEY_BITS-1:0] lru_key;
    logic [CNT_W-1:0]    cnt_m1;
    logic [KEY_BITS+VKEY_W-1:0] vic_ext;
    logic [CNT_W+OCNT_W-1:0]    cnt_ext;

    assign key_ext = {{KEY_BITS{1'b0}}, i_key};
    assign cnt_m1  = r_count - CNT_W'(1);

    // parallel compare; keys are distinct, so hit and lru are at most one-hot
    always_comb begin
        hit_rank = '0;
        lru_rank = '0;
        lru_key  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit[i] = r_valid[i] && (r_slot_key[i] == r_key);
            lru[i] = r_valid[i] && (r_rank[i] == cnt_m1[RANK_W-1:0]);
            hit_rank = hit_rank | (hit[i] ? r_rank[i] : '0);
            lru_rank = lru_rank | (lru[i] ? r_rank[i] : '0);
            lru_key  = lru_key  | (lru[i] ? r_slot_key[i] : '0);
        end
    end

    // lowest free slot
    assign free_oh = ~r_valid & (r_valid + CAPACITY'(1));
    assign hit_any = |hit;
    assign lru_any = |lru;
    assign full    = (r_count >= CNT_W'(CAPACITY)) || (&r_valid);

    always_comb begin
        ins_new  = 1'b0;
        do_rm    = 1'b0;
        rm       = '0;
        rm_rank  = '0;
        n_status = ST_MISS;
        n_victim = '0;
        unique case (r_act)
            ACT_INSERT: begin
                if (hit_any) begin
                    n_status = ST_DONE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ins_new  = 1'b1;
                    n_status = ST_DONE;
                end
            end
            ACT_EVICT: begin
                if (lru_any) begin
                    do_rm    = 1'b1;
                    rm       = lru;
                    rm_rank  = lru_rank;
                    n_victim = lru_key;
                    n_status = ST_DONE;
                end
            end
            ACT_ERASE: begin
                if (hit_any) begin
                    do_rm    = 1'b1;
                    rm       = hit;
                    rm_rank  = hit_rank;
                    n_status = ST_DONE;
                end
            end
            default: n_status = ST_MISS;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        key_we  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            n_rank[i] = r_rank[i];
            if (i_cmd.commit) begin
                if (r_act == ACT_INSERT && hit_any) begin
                    // touch: move to front, age the more recent ones
                    if (hit[i]) begin
                        n_rank[i] = '0;
                    end else if (r_valid[i] && r_rank[i] < hit_rank) begin
                        n_rank[i] = r_rank[i] + RANK_W'(1);
                    end
                end else if (ins_new) begin
                    if (free_oh[i]) begin
                        n_valid[i] = 1'b1;
                        n_rank[i]  = '0;
                        key_we[i]  = 1'b1;
                    end else if (r_valid[i]) begin
                        n_rank[i] = r_rank[i] + RANK_W'(1);
                    end
                end else if (do_rm) begin
                    // drop the slot and close the rank gap
                    if (rm[i]) begin
                        n_valid[i] = 1'b0;
                        n_rank[i]  = '0;
                    end else if (r_valid[i] && r_rank[i] > rm_rank) begin
                        n_rank[i] = r_rank[i] - RANK_W'(1);
                    end
                end
            end
        end
        if (i_cmd.commit) begin
            if (ins_new) begin
                n_count = r_count + CNT_W'(1);
            end else if (do_rm) begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= n_rank[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_key <= key_ext[KEY_BITS-1:0];
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_victim <= n_victim;
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (key_we[i]) begin
                r_slot_key[i] <= r_key;
            end
        end
    end

    assign vic_ext      = {{VKEY_W{1'b0}}, r_victim};
    assign cnt_ext      = {{OCNT_W{1'b0}}, r_count};
    assign o_status     = r_status;
    assign o_victim_key = vic_ext[VKEY_W-1:0];
    // the count only moves on a commit, which also reloads the result
    assign o_count      = cnt_ext[OCNT_W-1:0];

endmodule

`default_nettype wire

// ===== dv/lru_replacement_tracker_core_tb.sv =====
// ----------------------------------------------------------------------------
// lru_replacement_tracker_core_tb : self-checking bench for the LRU tracker
// Drives insert, evict, erase and unused action words through the valid/stall
// input channel and scores every result word against a recency-order model.
// Directed corner words come first, then phases of random words over small
// key pools. The sender bursts, the receiver stalls on its own pattern, and
// twice it holds off for a long stretch so the block backs up.
// ----------------------------------------------------------------------------

module lru_replacement_tracker_core_tb
    import lrt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // action code 3 has no member in the package; the block ignores it
    localparam logic [ACT_W-1:0]  ACT_UNUSED   = 2'd3;
    localparam logic [IKEY_W-1:0] KEY_MASK     = IKEY_W'((65'(1) << KEY_BITS) - 65'(1));
    localparam int                RAND_WORDS   = 925;
    localparam int                LIMIT_CYCLES = 300000;
    localparam int                SETTLE       = 20;
    localparam int                HOLDOFFS     = 2;
    localparam int                MAX_REPORTS  = 10;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [IKEY_W-1:0] key;
    } t_word;

    typedef struct {
        t_status            status;
        logic [VKEY_W-1:0]  victim;
        logic [OCNT_W-1:0]  count;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [ACT_W-1:0]   i_action = '0;
    logic [IKEY_W-1:0]  i_key = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [STAT_W-1:0]  o_status;
    logic [VKEY_W-1:0]  o_victim_key;
    logic [OCNT_W-1:0]  o_count;

    lru_replacement_tracker_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_victim_key (o_victim_key),
        .o_count      (o_count)
    );

    // ------------------------------------------------------------------
    // Recency model: slot keys, valid bits, ranks (0 = most recent)
    // ------------------------------------------------------------------
    logic [IKEY_W-1:0]  slot_key  [CAPACITY];
    bit                 slot_used [CAPACITY];
    logic [RANK_W-1:0]  slot_rank [CAPACITY];
    int                 held_count;

    t_word              action_words[$];     // words still to be offered
    t_result            pending_replies[$];  // results owed by the block

    // bench bookkeeping
    bit                 drive_en = 1'b0;
    bit                 word_taken = 1'b0;
    int                 words_sent = 0;
    int                 errors = 0;
    int                 cycle_count = 0;
    int                 n_done = 0;
    int                 n_miss = 0;
    int                 n_full = 0;
    int                 n_victims = 0;
    int                 peak_count = 0;
    int                 holdoffs_done = 0;
    int                 holdoff_left = 0;

    // Drop slot s and close the rank gap it leaves behind.
    function automatic void drop_slot(input int s);
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i] && slot_rank[i] > slot_rank[s])
                slot_rank[i]--;
        end
        slot_used[s] = 1'b0;
        slot_rank[s] = '0;
        if (held_count > 0)
            held_count--;
    endfunction

    // Apply one action word to the model and return the result word it owes.
    function automatic t_result track_action(input logic [ACT_W-1:0] act,
                                             input logic [IKEY_W-1:0] raw_key);
        t_result           r;
        logic [IKEY_W-1:0] k;
        logic [RANK_W-1:0] rk;
        int                hit;
        int                free_slot;
        int                lru_slot;
        k         = raw_key & KEY_MASK;
        r.status  = ST_MISS;
        r.victim  = '0;
        hit       = -1;
        free_slot = -1;
        lru_slot  = -1;
        // locate the held key, the first free slot and the least recent slot
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i] && slot_key[i] == k && hit < 0)
                hit = i;
            if (!slot_used[i] && free_slot < 0)
                free_slot = i;
            if (slot_used[i] && held_count > 0 && slot_rank[i] == held_count - 1
                    && lru_slot < 0)
                lru_slot = i;
        end
        case (act)
            ACT_INSERT: begin
                if (hit >= 0) begin
                    // touch: advance the key to the front, shift newer ones back
                    rk = slot_rank[hit];
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (slot_used[i] && slot_rank[i] < rk)
                            slot_rank[i]++;
                    end
                    slot_rank[hit] = '0;
                    r.status = ST_DONE;
                end else if (held_count >= CAPACITY || free_slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (slot_used[i])
                            slot_rank[i]++;
                    end
                    slot_key[free_slot]  = k;
                    slot_used[free_slot] = 1'b1;
                    slot_rank[free_slot] = '0;
                    held_count++;
                    r.status = ST_DONE;
                end
            end
            ACT_EVICT: begin
                if (lru_slot >= 0) begin
                    r.victim = slot_key[lru_slot];
                    drop_slot(lru_slot);
                    r.status = ST_DONE;
                end
            end
            ACT_ERASE: begin
                if (hit >= 0) begin
                    drop_slot(hit);
                    r.status = ST_DONE;
                end
            end
            default: begin
                // unused code: nothing changes
            end
        endcase
        r.count = OCNT_W'(held_count);
        return r;
    endfunction

    task automatic push_word(input logic [ACT_W-1:0] act, input logic [IKEY_W-1:0] key);
        t_word w;
        w.act = act;
        w.key = key;
        action_words.push_back(w);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Run timeout: count cycles and bail out well past the slowest run
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, pending_replies.size());
            $display("FAIL lru_replacement_tracker_core");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input driver: present the head word at the falling edge, hold it
    // until the block takes it, and work in bursts with random gaps.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        logic              nv;
        logic [ACT_W-1:0]  na;
        logic [IKEY_W-1:0] nk;
        nv = i_in_valid;
        na = i_action;
        nk = i_key;
        if (drive_en) begin
            // retire the word the block took at the last rising edge
            if (i_in_valid && word_taken) begin
                action_words.delete(0);
                words_sent++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (action_words.size() != 0) begin
                    nv = 1'b1;
                    na = action_words[0].act;
                    nk = action_words[0].key;
                    burst_left--;
                end
            end
        end
        i_in_valid <= nv;
        i_action   <= na;
        i_key      <= nk;
    end

    // ------------------------------------------------------------------
    // Long hold-off: counted on the rising edge, read by the stall driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (holdoff_left > 0) begin
            holdoff_left--;
        end else if (holdoffs_done < HOLDOFFS && words_sent >= 300 + 350 * holdoffs_done) begin
            holdoff_left = $urandom_range(150, 300);
            holdoffs_done++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: a mode picked at random for a random stretch
    // (never, light, heavy, periodic), overridden by the hold-off.
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int mode_left  = 0;
    int phase_tick = 0;

    always @(negedge i_clk) begin
        logic ns;
        ns = 1'b0;
        if (drive_en) begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 150);
            end
            mode_left--;
            phase_tick++;
            case (stall_mode)
                1:       ns = ($urandom_range(0, 99) < 25);
                2:       ns = ($urandom_range(0, 99) < 75);
                3:       ns = (phase_tick % 3 == 0);
                default: ns = 1'b0;
            endcase
            if (holdoff_left > 0)
                ns = 1'b1;
        end
        i_out_stall <= ns;
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, predict every accepted input word and
    // score every accepted result word against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        word_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                word_taken = 1'b1;
                pending_replies.push_back(track_action(i_action, i_key));
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("unexpected result: status %0d victim %h count %0d",
                                 o_status, o_victim_key, o_count);
                end else begin
                    want = pending_replies.pop_front();
                    if (o_status !== want.status || o_victim_key !== want.victim
                            || o_count !== want.count) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display({"mismatch: status exp %0d got %0d, victim exp %h got %h,",
                                      " count exp %0d got %0d"},
                                     want.status, o_status, want.victim, o_victim_key,
                                     want.count, o_count);
                    end
                    case (want.status)
                        ST_DONE: n_done++;
                        ST_FULL: n_full++;
                        default: n_miss++;
                    endcase
                    if (want.victim != '0 || (want.status == ST_DONE && want.count < peak_count
                            && o_victim_key == want.victim))
                        n_victims++;
                    if (want.count > peak_count)
                        peak_count = want.count;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [IKEY_W-1:0] pool [32];
        int                pool_n;
        int                bias;
        int                phase_len;
        int                roll;
        int                ins_w;
        int                evict_w;
        int                counted;
        logic [ACT_W-1:0]  act;
        logic [IKEY_W-1:0] key;

        held_count = 0;
        for (int i = 0; i < CAPACITY; i++) begin
            slot_used[i] = 1'b0;
            slot_rank[i] = '0;
            slot_key[i]  = '0;
        end

        // directed: empty store, unused code, key extremes, fill to full,
        // full reject, touch when full, evict order, erase hit then miss
        push_word(ACT_EVICT, 16'h0000);
        push_word(ACT_ERASE, 16'h1234);
        push_word(ACT_UNUSED, 16'hFFFF);
        push_word(ACT_INSERT, 16'h0000);
        push_word(ACT_INSERT, 16'hFFFF);
        for (int i = 1; i <= 14; i++)
            push_word(ACT_INSERT, IKEY_W'(16'h1111 * i));
        push_word(ACT_INSERT, 16'h5A5A);
        push_word(ACT_INSERT, 16'h0000);
        push_word(ACT_EVICT, 16'hFFFF);
        push_word(ACT_ERASE, 16'h0000);
        push_word(ACT_ERASE, 16'h0000);
        push_word(ACT_UNUSED, 16'h0000);

        // random: phases over a fresh key pool, biased to fill, churn or drain
        counted = 0;
        while (counted < RAND_WORDS) begin
            pool_n    = $urandom_range(4, 28);
            bias      = $urandom_range(0, 2);
            phase_len = $urandom_range(30, 120);
            for (int i = 0; i < pool_n; i++)
                pool[i] = IKEY_W'($urandom_range(0, 16'hFFFF));
            ins_w   = (bias == 0) ? 70 : (bias == 1) ? 45 : 25;
            evict_w = (bias == 2) ? 40 : 20;
            for (int j = 0; j < phase_len; j++) begin
                roll = $urandom_range(0, 99);
                if (roll < ins_w)
                    act = ACT_INSERT;
                else if (roll < ins_w + evict_w)
                    act = ACT_EVICT;
                else if (roll < 97)
                    act = ACT_ERASE;
                else
                    act = ACT_UNUSED;
                // mostly pool keys so touches and erase hits happen
                if ($urandom_range(0, 9) == 0 || act == ACT_EVICT)
                    key = IKEY_W'($urandom_range(0, 16'hFFFF));
                else
                    key = pool[$urandom_range(0, pool_n - 1)];
                push_word(act, key);
                if (act != ACT_UNUSED)
                    counted++;
            end
        end

        // hold reset, then release it at a falling edge
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drive_en = 1'b1;

        // wait until every word is in and every result is out
        while (action_words.size() != 0 || pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("run covered %0d words: %0d done, %0d miss/empty, %0d full rejects",
                 words_sent, n_done, n_miss, n_full);
        $display("peak occupancy %0d of %0d, %0d long receiver hold-offs, %0d errors",
                 peak_count, CAPACITY, holdoffs_done, errors);
        if (errors == 0) begin
            $display("PASS lru_replacement_tracker_core");
        end else begin
            $display("FAIL lru_replacement_tracker_core");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/lrt_pkg.sv
rtl/core/lrt_ctrl.sv
rtl/core/lrt_dp.sv
rtl/core/lru_replacement_tracker_core.sv
dv/lru_replacement_tracker_core_tb.sv
